### rtl/core/slbm_pkg.sv
// ----------------------------------------------------------------------------
// Sound level bar meter package
// Shared widths, command and mode codes, meter thresholds and the thermometer
// encoder used by the sound level bar meter.
// ----------------------------------------------------------------------------
package slbm_pkg;

    // Fixed field widths
    localparam int CMD_W       = 2;
    localparam int MODE_W      = 2;
    localparam int GAIN_W      = 3;
    localparam int DEV_W       = 13;
    localparam int BAR_W       = 8;
    localparam int CNT_W       = 5;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;

    // Command codes carried on s_tuser
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MODE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Display modes
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BAR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEAK  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_THR = 1'b1;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 3'd5;
    localparam logic [DEV_W-1:0]  COUNT_THR_RESET = 13'd300;

    // Largest deviation that can be reported
    localparam logic [DEV_W-1:0] DEV_MAX = 13'd8191;

    // Thermometer thresholds, lowest LED first
    localparam logic [DEV_W-1:0] LEVEL_STEPS [BAR_W] = '{
        13'd50, 13'd228, 13'd406, 13'd584, 13'd762, 13'd940, 13'd1118, 13'd1300
    };

    // Bit i is set when the deviation is above threshold i.
    function automatic logic [BAR_W-1:0] thermometer(input logic [DEV_W-1:0] dev);
        logic [BAR_W-1:0] bar;
        bar = '0;
        for (int i = 0; i < BAR_W; i++) begin
            bar[i] = (dev > LEVEL_STEPS[i]);
        end
        return bar;
    endfunction

endpackage

### rtl/core/sound_level_bar_meter_top.sv
// ----------------------------------------------------------------------------
// Sound level bar meter
// VU meter with baseline calibration, thermometer bar, peak hold and an
// event counter, driven by a stream of converter samples and commands.
// ----------------------------------------------------------------------------
// The meter takes one request per clock cycle and returns exactly one result
// per request, in the cycle after it is accepted; all the work is done in a
// single pass of logic in front of the result register, so the sustained rate
// is one request per cycle as long as m_tready is held high. The result
// register doubles as the output buffer: a new request is accepted whenever
// that register is empty or is being emptied in the same cycle. s_tuser
// carries the command (sample, select mode, clear and recalibrate). After
// reset, and after every clear command, the first CAL_SAMPLES samples are
// summed and their truncated mean becomes the baseline; these samples are not
// shown and report a deviation of zero, all but the last with the calibrating
// flag set. The mean is formed with a multiplication by a fixed reciprocal,
// which is exact for every possible sum. Afterwards each sample yields the
// absolute difference from the baseline times gain, saturated to 13 bits,
// which drives the LEDs according to the selected mode. Configuration writes
// are always accepted and should only be issued while no request is in flight.
// ----------------------------------------------------------------------------
module sound_level_bar_meter_top #(
    parameter int CAL_SAMPLES = 30,   // samples averaged for the baseline, 1..31
    parameter int SAMPLE_BITS = 10    // converter resolution, 8..12
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // Request channel
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // tdata, low bit up: sample[SAMPLE_BITS], mode_sel[2], zero padding
    input  logic [((SAMPLE_BITS+2+7)/8)*8-1:0]        s_tdata,
    // tuser: cmd[2]
    input  logic [slbm_pkg::CMD_W-1:0]                s_tuser,
    // Result channel
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // tdata, low bit up: led_bar[8], deviation[13], calibrating[1], mode[2]
    output logic [slbm_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // Configuration write channel
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [slbm_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [slbm_pkg::CFG_DATA_W-1:0]           cfg_wdata
);
    import slbm_pkg::*;

    // Calibration sum width and the reciprocal used for the mean.
    // With L = ceil(log2 N) and M = ceil(2^(W+L) / N), the top bits of x*M
    // give floor(x / N) exactly for every x below 2^W.
    localparam int SUM_W  = SAMPLE_BITS + $clog2(CAL_SAMPLES + 1);
    localparam int DIV_L  = $clog2(CAL_SAMPLES);
    localparam int DIV_K  = SUM_W + DIV_L;
    localparam int DIV_M  = ((1 << DIV_K) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam int PROD_W = SUM_W + DIV_K + 1;
    localparam int DEVF_W = (SAMPLE_BITS + GAIN_W > DEV_W) ? SAMPLE_BITS + GAIN_W : DEV_W;

    // Configuration registers
    logic [GAIN_W-1:0]      gain_reg;
    logic [DEV_W-1:0]       count_thr_reg;

    // Meter state
    logic [MODE_W-1:0]      cur_mode_reg,    cur_mode_next;
    logic [SAMPLE_BITS-1:0] baseline_reg,    baseline_next;
    logic [SUM_W-1:0]       cal_sum_reg,     cal_sum_next;
    logic [CNT_W-1:0]       cal_count_reg,   cal_count_next;
    logic                   cal_active_reg,  cal_active_next;
    logic [DEV_W-1:0]       peak_level_reg,  peak_level_next;
    logic [BAR_W-1:0]       peak_bar_reg,    peak_bar_next;
    logic [BAR_W-1:0]       event_count_reg, event_count_next;
    logic [BAR_W-1:0]       shown_bar_reg,   shown_bar_next;

    // Result register
    logic                   m_valid_reg,     m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg,      m_data_next;

    // Request fields and working values
    logic                   s_accept;
    logic [SAMPLE_BITS-1:0] smp;
    logic [MODE_W-1:0]      mode_sel;
    logic [SUM_W-1:0]       cal_sum_add;
    logic [CNT_W-1:0]       cal_count_inc;
    logic                   cal_done;
    logic [PROD_W-1:0]      mean_prod;
    logic [SAMPLE_BITS-1:0] diff;
    logic [DEVF_W-1:0]      dev_full;
    logic [DEV_W-1:0]       dev;
    logic [BAR_W-1:0]       dev_bar;
    logic [DEV_W-1:0]       dev_out;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign smp      = s_tdata[SAMPLE_BITS-1:0];
    assign mode_sel = s_tdata[SAMPLE_BITS +: MODE_W];

    // Calibration: running sum, count, and the mean once the count completes.
    // The count wraps at its width, so a wrap to zero also ends the run.
    assign cal_sum_add   = cal_sum_reg + SUM_W'(smp);
    assign cal_count_inc = cal_count_reg + CNT_W'(1);
    assign cal_done      = (cal_count_inc >= CNT_W'(CAL_SAMPLES)) || (cal_count_inc == '0);
    assign mean_prod     = PROD_W'(cal_sum_add) * PROD_W'(DIV_M);

    // Scaled absolute deviation, saturated to the reported width
    assign diff     = (smp >= baseline_reg) ? (smp - baseline_reg) : (baseline_reg - smp);
    assign dev_full = DEVF_W'(diff) * DEVF_W'(gain_reg);
    assign dev      = (dev_full > DEVF_W'(DEV_MAX)) ? DEV_MAX : dev_full[DEV_W-1:0];
    assign dev_bar  = thermometer(dev);

    always_comb begin
        cur_mode_next    = cur_mode_reg;
        baseline_next    = baseline_reg;
        cal_sum_next     = cal_sum_reg;
        cal_count_next   = cal_count_reg;
        cal_active_next  = cal_active_reg;
        peak_level_next  = peak_level_reg;
        peak_bar_next    = peak_bar_reg;
        event_count_next = event_count_reg;
        shown_bar_next   = shown_bar_reg;
        dev_out          = '0;

        case (s_tuser)
            CMD_SAMPLE: begin
                if (cal_active_reg) begin
                    // Calibration samples are summed but never shown.
                    if (cal_done) begin
                        baseline_next   = mean_prod[DIV_K +: SAMPLE_BITS];
                        cal_sum_next    = '0;
                        cal_count_next  = '0;
                        cal_active_next = 1'b0;
                    end else begin
                        cal_sum_next   = cal_sum_add;
                        cal_count_next = cal_count_inc;
                    end
                end else begin
                    dev_out = dev;
                    case (cur_mode_reg)
                        MODE_BAR: begin
                            shown_bar_next = dev_bar;
                        end
                        MODE_PEAK: begin
                            // The held bar only gains bits when a new peak is set.
                            if (dev > peak_level_reg) begin
                                peak_bar_next   = peak_bar_reg | dev_bar;
                                peak_level_next = dev;
                            end
                            shown_bar_next = peak_bar_next;
                        end
                        MODE_COUNT: begin
                            if (dev > count_thr_reg) begin
                                event_count_next = event_count_reg + BAR_W'(1);
                            end
                            shown_bar_next = event_count_next;
                        end
                        default: begin
                            // No mode chosen yet: the display is left alone.
                        end
                    endcase
                end
            end
            CMD_MODE: begin
                if (mode_sel != MODE_NONE) begin
                    cur_mode_next = mode_sel;
                end
            end
            CMD_CLEAR: begin
                peak_level_next  = '0;
                peak_bar_next    = '0;
                event_count_next = '0;
                cal_sum_next     = '0;
                cal_count_next   = '0;
                cal_active_next  = 1'b1;
            end
            default: begin
                // Unused command code: nothing changes.
            end
        endcase
    end

    // Result register: loaded on every accepted request, emptied when taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
            m_data_next  = {cur_mode_next, cal_active_next, dev_out, shown_bar_next};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg        <= GAIN_RESET;
            count_thr_reg   <= COUNT_THR_RESET;
            cur_mode_reg    <= MODE_NONE;
            baseline_reg    <= '0;
            cal_sum_reg     <= '0;
            cal_count_reg   <= '0;
            cal_active_reg  <= 1'b1;
            peak_level_reg  <= '0;
            peak_bar_reg    <= '0;
            event_count_reg <= '0;
            shown_bar_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_GAIN:      gain_reg      <= cfg_wdata[GAIN_W-1:0];
                    REG_COUNT_THR: count_thr_reg <= cfg_wdata[DEV_W-1:0];
                    default:       gain_reg      <= gain_reg;
                endcase
            end
            if (s_accept) begin
                cur_mode_reg    <= cur_mode_next;
                baseline_reg    <= baseline_next;
                cal_sum_reg     <= cal_sum_next;
                cal_count_reg   <= cal_count_next;
                cal_active_reg  <= cal_active_next;
                peak_level_reg  <= peak_level_next;
                peak_bar_reg    <= peak_bar_next;
                event_count_reg <= event_count_next;
                shown_bar_reg   <= shown_bar_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // The calibration count never reaches the sample total.
    a_cal_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_count_reg < CNT_W'(CAL_SAMPLES))
        else $error("calibration count out of range");

    // Outside calibration the running sum and count are idle at zero.
    a_cal_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !cal_active_reg |-> (cal_count_reg == '0) && (cal_sum_reg == '0))
        else $error("calibration accumulator not cleared");

    // A result flagged as calibrating never reports a deviation.
    a_cal_no_dev: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[BAR_W + DEV_W]) |-> (m_tdata[BAR_W +: DEV_W] == '0))
        else $error("deviation reported during calibration");

    // The held peak bar only gains bits unless a clear is accepted.
    a_peak_bar_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser != CMD_CLEAR))
        |=> ((peak_bar_reg & $past(peak_bar_reg)) == $past(peak_bar_reg)))
        else $error("peak bar lost bits without a clear");

    // Every accepted request leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted request produced no result");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Sound level bar meter testbench
// Drives sample, mode, clear and unused-command requests into the meter. A
// small in-bench model of the meter predicts every result. Each result is
// then checked field by field against that prediction. The run walks through
// several gain and threshold settings, with random idling on both sides and
// one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import slbm_pkg::*;

    // The block is built with its default calibration length and resolution.
    localparam int CAL_LEN     = 30;
    localparam int SMP_W       = 10;
    localparam int SMP_TOP     = (1 << SMP_W) - 1;
    localparam int S_TDATA_W   = ((SMP_W + 2 + 7) / 8) * 8;
    localparam int LONG_HOLD   = 200;
    localparam int MAX_REPORTS = 10;

    // The package has no name for the fourth command code, which the meter
    // must simply ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One result as it appears on m_tdata, highest field first.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              calibrating;
        logic [DEV_W-1:0]  deviation;
        logic [BAR_W-1:0]  led_bar;
    } display_t;

    // ------------------------------------------------------------------------
    // Meter model and result checker. It holds its own copy of the meter
    // state and registers. Each accepted request is stepped through the model
    // and the display it should produce is queued. Results are then checked
    // in order against that queue.
    // ------------------------------------------------------------------------
    class bar_meter_tracker_t;
        logic [GAIN_W-1:0] gain;
        logic [DEV_W-1:0]  count_thr;
        logic [MODE_W-1:0] mode;
        logic [SMP_W-1:0]  baseline;
        logic [14:0]       cal_sum;
        logic [CNT_W-1:0]  cal_count;
        logic              cal_active;
        logic [DEV_W-1:0]  peak_level;
        logic [BAR_W-1:0]  peak_bar;
        logic [BAR_W-1:0]  event_count;
        logic [BAR_W-1:0]  shown_bar;
        display_t          awaited[$];
        int unsigned       noted;
        int unsigned       checked;
        int unsigned       mismatches;
        int unsigned       cal_done;

        function new();
            gain        = GAIN_RESET;
            count_thr   = COUNT_THR_RESET;
            mode        = MODE_NONE;
            baseline    = '0;
            cal_sum     = '0;
            cal_count   = '0;
            cal_active  = 1'b1;
            peak_level  = '0;
            peak_bar    = '0;
            event_count = '0;
            shown_bar   = '0;
            noted       = 0;
            checked     = 0;
            mismatches  = 0;
            cal_done    = 0;
        endfunction

        function logic [BAR_W-1:0] level_pattern(logic [DEV_W-1:0] dev);
            logic [BAR_W-1:0] bar;
            bar = '0;
            for (int i = 0; i < BAR_W; i++) begin
                if (dev > LEVEL_STEPS[i]) bar[i] = 1'b1;
            end
            return bar;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_GAIN) begin
                gain = val[GAIN_W-1:0];
            end else begin
                count_thr = val;
            end
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [SMP_W-1:0] smp,
                                   logic [MODE_W-1:0] sel);
            display_t    want;
            logic [SMP_W-1:0] diff;
            int unsigned scaled;
            want.deviation = '0;
            noted++;
            case (cmd)
                CMD_SAMPLE: begin
                    if (cal_active) begin
                        // Calibration samples only build up the baseline.
                        cal_sum   = cal_sum + smp;
                        cal_count = cal_count + 1'b1;
                        if (cal_count >= CAL_LEN || cal_count == 0) begin
                            baseline   = SMP_W'(cal_sum / CAL_LEN);
                            cal_sum    = '0;
                            cal_count  = '0;
                            cal_active = 1'b0;
                            cal_done++;
                        end
                    end else begin
                        diff   = (smp >= baseline) ? smp - baseline : baseline - smp;
                        scaled = diff * gain;
                        if (scaled > DEV_MAX) scaled = DEV_MAX;
                        want.deviation = DEV_W'(scaled);
                        case (mode)
                            MODE_BAR: begin
                                shown_bar = level_pattern(want.deviation);
                            end
                            MODE_PEAK: begin
                                if (want.deviation > peak_level) begin
                                    peak_bar   = peak_bar | level_pattern(want.deviation);
                                    peak_level = want.deviation;
                                end
                                shown_bar = peak_bar;
                            end
                            MODE_COUNT: begin
                                if (want.deviation > count_thr) begin
                                    event_count = event_count + 1'b1;
                                end
                                shown_bar = event_count;
                            end
                            default: begin
                                // No mode chosen yet: measured but not shown.
                            end
                        endcase
                    end
                end
                CMD_MODE: begin
                    if (sel != MODE_NONE) mode = sel;
                end
                CMD_CLEAR: begin
                    peak_level  = '0;
                    peak_bar    = '0;
                    event_count = '0;
                    cal_sum     = '0;
                    cal_count   = '0;
                    cal_active  = 1'b1;
                end
                default: begin
                end
            endcase
            want.led_bar     = shown_bar;
            want.calibrating = cal_active;
            want.mode        = mode;
            awaited.push_back(want);
        endfunction

        function void check_result(display_t got);
            display_t want;
            bit       orphan;
            checked++;
            orphan = (awaited.size() == 0);
            if (orphan) begin
                want = 'x;
            end else begin
                want = awaited.pop_front();
            end
            if (orphan || got.led_bar !== want.led_bar || got.deviation !== want.deviation ||
                got.calibrating !== want.calibrating || got.mode !== want.mode) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    if (orphan) begin
                        $display({"ERROR: result %0d with nothing awaited: ",
                                  "bar=%b dev=%0d cal=%0d mode=%0d"},
                                 checked, got.led_bar, got.deviation, got.calibrating,
                                 got.mode);
                    end else begin
                        $display({"ERROR: result %0d: expected bar=%b dev=%0d cal=%0d mode=%0d,",
                                  " got bar=%b dev=%0d cal=%0d mode=%0d"},
                                 checked, want.led_bar, want.deviation, want.calibrating,
                                 want.mode, got.led_bar, got.deviation, got.calibrating,
                                 got.mode);
                    end
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test
    // ------------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // sample[10], mode_sel[2], zero padding
    logic [CMD_W-1:0]      s_tuser;    // cmd[2]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // led_bar[8], deviation[13], calibrating[1], mode[2]
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bar_meter_tracker_t meter = new();

    // Idling is allowed on both sides until the final stretch of the run.
    bit idle_en      = 1'b1;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit hold_request = 1'b0;
    // Level around which calibration samples are drawn after each clear.
    int cal_centre   = 0;

    sound_level_bar_meter_top #(
        .CAL_SAMPLES (CAL_LEN),
        .SAMPLE_BITS (SMP_W)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Every accepted result is checked at the edge that accepts it. The values
    // read here are those from before the edge, because all drivers use
    // nonblocking assignments.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            meter.check_result(display_t'(m_tdata));
        end
    end

    // Receiver. It mostly takes results at once, but stalls in short random
    // bursts. Once in the run it holds off for a long, counted stretch, so
    // that the result register fills and the meter stops accepting requests.
    initial begin
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Offers one request, sometimes after a short random gap. It returns at
    // the edge that accepts the request, with s_tvalid still high. The next
    // request can then follow back to back.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [SMP_W-1:0] smp,
                                logic [MODE_W-1:0] sel);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - SMP_W - MODE_W){1'b0}}, sel, smp};
        do @(posedge aclk); while (s_tready !== 1'b1);
        meter.note_request(cmd, smp, sel);
    endtask

    // Leaves the cfg channel valid on return. Several writes can then run
    // back to back without lowering and raising cfg_valid in the same step.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        meter.write_reg(idx, val);
    endtask

    // Stops offering requests and waits until every result has come back.
    // Each request gives exactly one result, so the wait ends once every
    // awaited result has been checked.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (meter.awaited.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // The meter must be idle while its registers change. The upper data bits
    // of a gain write are ignored by the block, so they carry random values.
    task automatic set_registers(logic [GAIN_W-1:0] g, logic [DEV_W-1:0] thr);
        settle();
        write_register(REG_GAIN, {(CFG_DATA_W - GAIN_W)'($urandom), g});
        write_register(REG_COUNT_THR, thr);
        cfg_valid <= 1'b0;
    endtask

    // Most samples fall near the current baseline, at a few different
    // spreads, so that every bar threshold is crossed. The rest are spread
    // over the whole range. During calibration the samples cluster around a
    // level picked at the last clear; that level is often one of the two
    // range ends, which pushes the deviation to its extremes later on.
    function automatic logic [SMP_W-1:0] next_sample();
        int v;
        int spread;
        if (meter.cal_active) begin
            v = cal_centre + int'($urandom_range(0, 30)) - 15;
        end else if ($urandom_range(0, 2) == 0) begin
            v = int'($urandom_range(0, SMP_TOP));
        end else begin
            case ($urandom_range(0, 3))
                0:       spread = 12;
                1:       spread = 80;
                2:       spread = 300;
                default: spread = SMP_TOP;
            endcase
            v = int'(meter.baseline) + int'($urandom_range(0, 2 * spread)) - spread;
        end
        if (v < 0) v = 0;
        if (v > SMP_TOP) v = SMP_TOP;
        return SMP_W'(v);
    endfunction

    // One phase of random traffic: mostly samples, with some mode changes,
    // clears and unused commands mixed in. Rates are given per thousand.
    // The phase opens by selecting its preferred mode. From calm_from on,
    // neither side idles any more.
    task automatic run_phase(int items, logic [MODE_W-1:0] pref, int clear_pm,
                             int mode_pm, int calm_from);
        int r;
        send_request(CMD_MODE, SMP_W'($urandom), pref);
        for (int n = 1; n < items; n++) begin
            if (n == calm_from) idle_en = 1'b0;
            r = $urandom_range(0, 999);
            if (r < clear_pm) begin
                case ($urandom_range(0, 3))
                    0:       cal_centre = 0;
                    1:       cal_centre = SMP_TOP;
                    default: cal_centre = $urandom_range(0, SMP_TOP);
                endcase
                send_request(CMD_CLEAR, SMP_W'($urandom), MODE_W'($urandom));
            end else if (r < clear_pm + mode_pm) begin
                send_request(CMD_MODE, SMP_W'($urandom),
                             ($urandom_range(0, 9) < 7) ? pref : MODE_W'($urandom));
            end else if (r < clear_pm + mode_pm + 8) begin
                send_request(CMD_UNUSED, SMP_W'($urandom), MODE_W'($urandom));
            end else begin
                send_request(CMD_SAMPLE, next_sample(), MODE_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_SAMPLE;
        cfg_valid <= 1'b0;
        cfg_index <= REG_GAIN;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, run with the reset gain of five and threshold of
        // 300. First an unused command and a mode select of zero, neither of
        // which may change anything.
        send_request(CMD_UNUSED, SMP_W'(SMP_TOP), MODE_COUNT);
        send_request(CMD_MODE, '0, MODE_NONE);
        // Full calibration from alternating range ends; the mean truncates
        // to 511.
        for (int k = 0; k < CAL_LEN; k++) begin
            send_request(CMD_SAMPLE, (k % 2 == 0) ? SMP_W'(SMP_TOP) : SMP_W'(0), MODE_W'(k));
        end
        // With no mode chosen the sample is measured but the LEDs stay dark.
        send_request(CMD_SAMPLE, SMP_W'(SMP_TOP), MODE_NONE);
        // Bar mode: both range ends, no deviation, and a deviation of exactly
        // the lowest threshold followed by one just above it.
        send_request(CMD_MODE, '0, MODE_BAR);
        send_request(CMD_SAMPLE, SMP_W'(SMP_TOP), MODE_NONE);
        send_request(CMD_SAMPLE, '0, MODE_NONE);
        send_request(CMD_SAMPLE, SMP_W'(511), MODE_NONE);
        send_request(CMD_SAMPLE, SMP_W'(521), MODE_NONE);
        send_request(CMD_SAMPLE, SMP_W'(522), MODE_NONE);
        // Peak hold: a mid peak, a lower sample that must not alter it, then
        // a full-scale peak.
        send_request(CMD_MODE, '0, MODE_PEAK);
        send_request(CMD_SAMPLE, SMP_W'(600), MODE_NONE);
        send_request(CMD_SAMPLE, SMP_W'(560), MODE_NONE);
        send_request(CMD_SAMPLE, SMP_W'(SMP_TOP), MODE_NONE);
        // Event count: one counted sample and one that is not.
        send_request(CMD_MODE, '0, MODE_COUNT);
        send_request(CMD_SAMPLE, SMP_W'(SMP_TOP), MODE_NONE);
        send_request(CMD_SAMPLE, SMP_W'(511), MODE_NONE);
        // A clear restarts calibration but keeps the mode and the LEDs.
        send_request(CMD_CLEAR, '0, MODE_NONE);
        send_request(CMD_SAMPLE, SMP_W'(5), MODE_NONE);

        // Random phases, each under its own register setting. The third
        // phase starts with the long output hold-off. The gain-zero phase
        // must give no deviation at all. The last phase uses the highest gain
        // and a threshold of zero, with no clears, so the event count wraps;
        // its tail runs without any idling.
        run_phase(340, MODE_BAR, 4, 30, -1);
        set_registers(3'd1, 13'd0);
        run_phase(300, MODE_PEAK, 4, 20, -1);
        set_registers(3'd7, 13'd7161);
        hold_request = 1'b1;
        run_phase(260, MODE_COUNT, 4, 20, -1);
        set_registers(3'd0, 13'd8191);
        run_phase(150, MODE_BAR, 5, 30, -1);
        set_registers(3'd3, DEV_W'($urandom_range(0, 8191)));
        run_phase(200, MODE_PEAK, 6, 30, -1);
        set_registers(3'd7, 13'd0);
        run_phase(420, MODE_COUNT, 0, 4, 170);

        settle();
        repeat (8) @(posedge aclk);

        $display("Summary: %0d requests driven, %0d results checked, %0d baseline calibrations,",
                 meter.noted, meter.checked, meter.cal_done);
        $display({"         six gain/threshold settings, random idling and a %0d-cycle",
                  " output hold-off; %0d mismatches."},
                 LONG_HOLD, meter.mismatches);
        if (meter.mismatches == 0 && meter.awaited.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Safety net, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timeout with %0d results still awaited", meter.awaited.size());
        $display("Verification failed");
        $finish;
    end

endmodule

### sound_level_bar_meter_top.f
rtl/core/slbm_pkg.sv
rtl/core/sound_level_bar_meter_top.sv
tb/testbench.sv
